// File: rtl/core/rism_pkg.sv
// rism_pkg: shared types, command codes and sizing constants for the
// row-indexed sparse matrix-vector multiply. no dependencies.
`timescale 1ns / 1ps

package rism_pkg;

   localparam int DEF_MAX_DIM     = 64;
   localparam int DEF_STORE_DEPTH = 1024;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int DIM_W  = 7;   // width of the vector_length register
   localparam int SLOT_W = 17;  // holds any slot number up to 65536 and any index word
   localparam int ACC_W  = 82;  // exact sum of up to 65537 q32.32 products

   localparam logic [1:0] CMD_STORE  = 2'd0;
   localparam logic [1:0] CMD_VECTOR = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         address;
      logic signed [31:0] value;
      logic [10:0]        index_word;
   } req_type;

   typedef struct packed {
      logic [5:0]         row;
      logic signed [31:0] row_value;
      logic               error;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   // floor shift by 16 then saturate to signed 32 bits
   function automatic logic [31:0] sat_result(input logic [ACC_W-1:0] acc);
      logic [ACC_W-48:0] top;
      top = acc[ACC_W-1:47];
      if ((&top) || !(|top)) begin
         return acc[47:16];
      end
      return acc[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

endpackage

// File: rtl/core/row_indexed_sparse_matvec.sv
// row_indexed_sparse_matvec: top level; request queue, engine, result queue
// and the vector_length register. depends on rism_pkg, rism_fifo, rism_engine.
// a load is written to its store as the engine takes it from the request queue;
// loads go one per cycle while the engine is idle. a run checks the header, then
// walks each row one stored term at a time, set by the single read port of each store.
// a bad header gives one result, flagged as an error and marked last.
// reset (synchronous, active high) empties both queues, idles the engine and sets
// vector_length to 1; the stores keep their contents and need no clearing pass.
`timescale 1ns / 1ps

module row_indexed_sparse_matvec #(
   parameter int MAX_DIM     = rism_pkg::DEF_MAX_DIM,
   parameter int STORE_DEPTH = rism_pkg::DEF_STORE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // request side
   input  logic                      req_push,
   output logic                      req_full,
   input  rism_pkg::req_type         req_data,
   // result side
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rism_pkg::rsp_type         rsp_data,
   // vector_length register
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rism_pkg::DIM_W-1:0] csr_data
);
   import rism_pkg::*;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [DIM_W-1:0] vector_length_ff;
   fifo_stat_type    cq_stat, rq_stat;
   logic [REQ_W-1:0] cq_head;
   logic [RSP_W-1:0] rq_head;
   req_type          cq_data;
   rsp_type          rq_data;
   logic             cq_pop, rq_push;

   // register is always writable; the user must change it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         vector_length_ff <= csr_data;
      end
   end

   // front: request queue, lets the engine stall while pushes go on until the queue is full
   rism_fifo #(
      .WIDTH (REQ_W),
      .DEPTH (DEF_QUEUE_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .pop       (cq_pop),
      .head_data (cq_head),
      .stat      (cq_stat)
   );

   assign req_full = cq_stat.full;
   assign cq_data  = cq_head;

   // back: store writes and the row walk
   rism_engine #(
      .MAX_DIM     (MAX_DIM),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .vector_length (vector_length_ff),
      .cq_stat       (cq_stat),
      .cq_data       (cq_data),
      .cq_pop        (cq_pop),
      .rq_stat       (rq_stat),
      .rq_push       (rq_push),
      .rq_data       (rq_data)
   );

   // result queue, decouples the engine from a stalled consumer
   rism_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (DEF_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_data),
      .pop       (rsp_pop),
      .head_data (rq_head),
      .stat      (rq_stat)
   );

   assign rsp_empty = rq_stat.empty;
   assign rsp_data  = rq_head;

endmodule

// File: rtl/core/rism_fifo.sv
// rism_fifo: small register queue used between the ports and the engine.
// depends on rism_pkg for the status struct.
`timescale 1ns / 1ps

module rism_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       head_data,
   output rism_pkg::fifo_stat_type stat
);
   import rism_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == (PW+1)'(DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/rism_engine.sv
// rism_engine: back end; owns the value, index and vector stores and walks
// the rows of a run one multiply-accumulate at a time. depends on rism_pkg.
`timescale 1ns / 1ps

module rism_engine #(
   parameter int MAX_DIM     = rism_pkg::DEF_MAX_DIM,
   parameter int STORE_DEPTH = rism_pkg::DEF_STORE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [rism_pkg::DIM_W-1:0] vector_length,
   input  rism_pkg::fifo_stat_type cq_stat,
   input  rism_pkg::req_type       cq_data,
   output logic                    cq_pop,
   input  rism_pkg::fifo_stat_type rq_stat,
   output logic                    rq_push,
   output rism_pkg::rsp_type       rq_data
);
   import rism_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int VW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(STORE_DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HDR   = 4'd1;
   localparam logic [3:0] S_ROW   = 4'd2;
   localparam logic [3:0] S_ROW2  = 4'd3;
   localparam logic [3:0] S_ROW3  = 4'd4;
   localparam logic [3:0] S_K_RD  = 4'd5;
   localparam logic [3:0] S_K_COL = 4'd6;
   localparam logic [3:0] S_K_MUL = 4'd7;
   localparam logic [3:0] S_K_ACC = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;

   // stores
   logic signed [31:0] value_mem  [STORE_DEPTH];
   logic [10:0]        index_mem  [STORE_DEPTH];
   logic signed [31:0] vector_mem [MAX_DIM];

   logic [3:0]         state_ff, state_in;
   logic [DIM_W-1:0]   n_ff, n_in;
   logic [DIM_W-1:0]   i_ff, i_in;
   logic [SLOT_W-1:0]  k_ff, k_in;
   logic [SLOT_W-1:0]  start_ff, start_in;
   logic [SLOT_W-1:0]  end_ff, end_in;
   logic               err_ff, err_in;
   logic signed [31:0] val_hold_ff, val_hold_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   rsp_type            res_ff, res_in;

   logic [10:0]        idx_q_ff;
   logic               idx_ok_ff;
   logic signed [31:0] val_q_ff;
   logic               val_ok_ff;
   logic signed [31:0] vec_q_ff;

   logic               idx_re, val_re, vec_re;
   logic [SLOT_W-1:0]  idx_ra, val_ra;
   logic [VW-1:0]      vec_ra;
   logic               st_we, vec_we;
   logic [SLOT_W-1:0]  wr_slot;

   logic [SLOT_W-1:0]  idx_d, i_slot, n_p1, k_p1, col;
   logic signed [31:0] val_d;
   logic [DIM_W-1:0]   n_clamp;
   logic               bad_ptr;

   assign wr_slot = SLOT_W'(cq_data.address);
   assign idx_d   = idx_ok_ff ? SLOT_W'(idx_q_ff) : '0;
   assign val_d   = val_ok_ff ? val_q_ff : 32'sd0;
   assign i_slot  = SLOT_W'(i_ff);
   assign n_p1    = SLOT_W'(n_ff) + SLOT_W'(1);
   assign k_p1    = k_ff + SLOT_W'(1);
   assign col     = idx_d;
   assign rq_data = res_ff;

   always_comb begin
      if (vector_length == '0) begin
         n_clamp = DIM_W'(1);
      end else if (vector_length > DIM_W'(MAX_DIM)) begin
         n_clamp = DIM_W'(MAX_DIM);
      end else begin
         n_clamp = vector_length;
      end
   end

   assign bad_ptr = (i_slot >= DEPTH_S) || (start_ff < n_p1) || (start_ff > DEPTH_S) ||
                    (i_slot + SLOT_W'(1) >= DEPTH_S) || (idx_d < n_p1) || (idx_d > DEPTH_S);

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      err_in      = err_ff;
      val_hold_in = val_hold_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      cq_pop      = 1'b0;
      rq_push     = 1'b0;
      idx_re      = 1'b0;
      val_re      = 1'b0;
      vec_re      = 1'b0;
      idx_ra      = '0;
      val_ra      = '0;
      vec_ra      = '0;
      st_we       = 1'b0;
      vec_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!cq_stat.empty) begin
               cq_pop = 1'b1;
               case (cq_data.command)
                  CMD_STORE: begin
                     st_we = (wr_slot < DEPTH_S);
                  end
                  CMD_VECTOR: begin
                     vec_we = (wr_slot < SLOT_W'(MAX_DIM));
                  end
                  CMD_RUN: begin
                     n_in     = n_clamp;
                     idx_re   = 1'b1;
                     state_in = S_HDR;
                  end
                  default: ;
               endcase
            end
         end
         S_HDR: begin
            if (idx_d != n_p1) begin
               res_in.row       = '0;
               res_in.row_value = '0;
               res_in.error     = 1'b1;
               res_in.last      = 1'b1;
               state_in         = S_EMIT;
            end else begin
               i_in     = '0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            idx_re   = 1'b1;
            idx_ra   = i_slot;
            val_re   = 1'b1;
            val_ra   = i_slot;
            vec_re   = 1'b1;
            vec_ra   = i_ff[VW-1:0];
            state_in = S_ROW2;
         end
         S_ROW2: begin
            // diagonal term; a diagonal slot past the store reads as zero
            start_in = idx_d;
            prod_in  = val_d * vec_q_ff;
            err_in   = (i_slot >= DEPTH_S);
            idx_re   = 1'b1;
            idx_ra   = i_slot + SLOT_W'(1);
            state_in = S_ROW3;
         end
         S_ROW3: begin
            end_in = idx_d;
            acc_in = {{(ACC_W-64){prod_ff[63]}}, prod_ff};
            k_in   = start_ff;
            if (bad_ptr) begin
               err_in   = 1'b1;
               state_in = S_FIN;
            end else if (start_ff < idx_d) begin
               state_in = S_K_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_K_RD: begin
            idx_re   = 1'b1;
            idx_ra   = k_ff;
            val_re   = 1'b1;
            val_ra   = k_ff;
            state_in = S_K_COL;
         end
         S_K_COL: begin
            val_hold_in = val_d;
            if (col >= SLOT_W'(n_ff)) begin
               // bad column: flag and skip the term
               err_in   = 1'b1;
               k_in     = k_p1;
               state_in = (k_p1 < end_ff) ? S_K_RD : S_FIN;
            end else begin
               vec_re   = 1'b1;
               vec_ra   = col[VW-1:0];
               state_in = S_K_MUL;
            end
         end
         S_K_MUL: begin
            prod_in  = val_hold_ff * vec_q_ff;
            state_in = S_K_ACC;
         end
         S_K_ACC: begin
            acc_in   = acc_ff + {{(ACC_W-64){prod_ff[63]}}, prod_ff};
            k_in     = k_p1;
            state_in = (k_p1 < end_ff) ? S_K_RD : S_FIN;
         end
         S_FIN: begin
            res_in.row       = i_ff[5:0];
            res_in.row_value = sat_result(acc_ff);
            res_in.error     = err_ff;
            res_in.last      = (i_ff + DIM_W'(1) == n_ff);
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            if (!rq_stat.full) begin
               rq_push = 1'b1;
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + DIM_W'(1);
                  state_in = S_ROW;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      err_ff      <= err_in;
      val_hold_ff <= val_hold_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
   end

   // storage memories, registered reads
   always_ff @(posedge clock) begin
      if (st_we) begin
         value_mem[wr_slot[AW-1:0]] <= cq_data.value;
         index_mem[wr_slot[AW-1:0]] <= cq_data.index_word;
      end
      if (idx_re) begin
         idx_q_ff  <= index_mem[idx_ra[AW-1:0]];
         idx_ok_ff <= (idx_ra < DEPTH_S);
      end
      if (val_re) begin
         val_q_ff  <= value_mem[val_ra[AW-1:0]];
         val_ok_ff <= (val_ra < DEPTH_S);
      end
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vector_mem[wr_slot[VW-1:0]] <= cq_data.value;
      end
      if (vec_re) begin
         vec_q_ff <= vector_mem[vec_ra];
      end
   end

endmodule

// File: rtl/core/rism_checker.sv
// rism_checker: port-level assertions for row_indexed_sparse_matvec, bound
// to the top level. depends on rism_pkg.
`timescale 1ns / 1ps

module rism_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input rism_pkg::rsp_type rsp_data
);
   import rism_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_free: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request queue full after reset");

   a_rsp_stays: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result dropped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting result changed");

endmodule

bind row_indexed_sparse_matvec rism_checker u_rism_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
